@@ src/rounded_rect_alpha_fill_macros.svh @@
// ============================================================================
// rounded_rect_alpha_fill_macros.svh
// Assertion macros shared by the rounded rectangle fill RTL.
// ============================================================================
`ifndef ROUNDED_RECT_ALPHA_FILL_MACROS_SVH
`define ROUNDED_RECT_ALPHA_FILL_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, disabled in reset
`define RRAF_ASSERT_IMPL(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("rraf assertion failed");

// next-cycle implication, disabled in reset
`define RRAF_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("rraf assertion failed");

`else

`define RRAF_ASSERT_IMPL(label, clk, rst_n, cond, prop)
`define RRAF_ASSERT_NEXT(label, clk, rst_n, cond, prop)

`endif

`endif

@@ src/rraf_pkg.sv @@
// ============================================================================
// rraf_pkg
// Widths, register indexes and defaults for the rounded rectangle fill.
// ============================================================================
`default_nettype none

package rraf_pkg;

    localparam int COORD_W   = 9;    // screen coordinate
    localparam int POS_W     = 10;   // signed rectangle edge
    localparam int SIZE_W    = 10;   // rectangle width / height
    localparam int RAD_W     = 9;    // corner radius
    localparam int PIX_W     = 32;   // ARGB8888
    localparam int CH_W      = 8;    // one color channel
    localparam int GEO_W     = 12;   // signed geometry sums and distances
    localparam int SQ_W      = 2 * GEO_W - 2;  // square of a distance
    localparam int RSQ_W     = 2 * RAD_W;      // square of the radius
    localparam int PROD_W    = 2 * CH_W;       // channel times alpha
    localparam int NUM_CH    = 3;
    localparam int ALPHA_LSB = 24;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam int IN_TDATA_W  = 56;   // 50 payload bits padded to bytes
    localparam int OUT_TDATA_W = 32;

    localparam int SCREEN_WIDTH_DEF  = 256;
    localparam int SCREEN_HEIGHT_DEF = 240;

    localparam logic [CH_W-1:0] CH_MAX = 8'hFF;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_RECT_LEFT     = 3'd0,
        REG_RECT_TOP      = 3'd1,
        REG_RECT_WIDTH    = 3'd2,
        REG_RECT_HEIGHT   = 3'd3,
        REG_CORNER_RADIUS = 3'd4,
        REG_FILL_COLOR    = 3'd5
    } cfg_index_t;

endpackage

`default_nettype wire

@@ src/rounded_rect_alpha_fill.sv @@
// ============================================================================
// rounded_rect_alpha_fill
// Blends a rounded rectangle of one ARGB color over a stream of pixels.
// ============================================================================
//
//  channel   dir  tdata fields (low bit up)                     tuser
//  s_*       in   pixel_x[8:0] pixel_y[17:9] back_pixel[49:18]   -
//  m_*       out  out_pixel[31:0]                                covered
//  cfg_*     in   register index, write data                     -
//
//  Four register stages: input capture, box and corner test, squares and
//  channel products, radius compare and divide by 255.
//  One word per clock when m_tready stays high.
//  Each stage holds under stall and a bubble is squeezed out, so the input
//  side keeps taking words until all four stages are full.
//  Reset clears the valid bits and the configuration registers.
//
`default_nettype none

`include "rounded_rect_alpha_fill_macros.svh"

module rounded_rect_alpha_fill
    import rraf_pkg::*;
#(
    parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // pixel_x[8:0], pixel_y[17:9], back_pixel[49:18], zero pad
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,

    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // out_pixel[31:0]
    output logic [OUT_TDATA_W-1:0]      m_tdata,
    // covered[0]
    output logic                        m_tuser,

    input  wire logic                   cfg_we,
    input  wire logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int SCR_W = COORD_W + 1;
    localparam logic [SCR_W-1:0] SCR_WIDTH  = SCR_W'(SCREEN_WIDTH);
    localparam logic [SCR_W-1:0] SCR_HEIGHT = SCR_W'(SCREEN_HEIGHT);

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    logic signed [POS_W-1:0] left_reg;
    logic signed [POS_W-1:0] top_reg;
    logic [SIZE_W-1:0]       width_reg;
    logic [SIZE_W-1:0]       height_reg;
    logic [RAD_W-1:0]        radius_reg;
    logic [PIX_W-1:0]        fill_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg   <= '0;
            top_reg    <= '0;
            width_reg  <= '0;
            height_reg <= '0;
            radius_reg <= '0;
            fill_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_RECT_LEFT:     left_reg   <= cfg_wdata[POS_W-1:0];
                REG_RECT_TOP:      top_reg    <= cfg_wdata[POS_W-1:0];
                REG_RECT_WIDTH:    width_reg  <= cfg_wdata[SIZE_W-1:0];
                REG_RECT_HEIGHT:   height_reg <= cfg_wdata[SIZE_W-1:0];
                REG_CORNER_RADIUS: radius_reg <= cfg_wdata[RAD_W-1:0];
                REG_FILL_COLOR:    fill_reg   <= cfg_wdata;
                default:           ;
            endcase
        end
    end

    // Edge and corner-center positions, refreshed every cycle. A word
    // accepted right after a write only reads them one stage later.
    logic signed [GEO_W-1:0] x_geo, y_geo, w_geo, h_geo, r_geo;
    logic signed [GEO_W-1:0] xl_reg, xw_reg, xr1_reg, xwr_reg;
    logic signed [GEO_W-1:0] yt_reg, yh_reg, yr1_reg, yhr_reg;
    logic [RSQ_W-1:0]        rsq_reg;
    logic [RSQ_W-1:0]        rsq_next;

    assign x_geo = GEO_W'(left_reg);
    assign y_geo = GEO_W'(top_reg);
    assign w_geo = signed'(GEO_W'(width_reg));
    assign h_geo = signed'(GEO_W'(height_reg));
    assign r_geo = signed'(GEO_W'(radius_reg));
    assign rsq_next = radius_reg * radius_reg;

    always_ff @(posedge clk)
    begin
        xl_reg  <= x_geo;
        xw_reg  <= x_geo + w_geo;
        xr1_reg <= x_geo + r_geo - GEO_W'(1);
        xwr_reg <= x_geo + w_geo - r_geo;
        yt_reg  <= y_geo;
        yh_reg  <= y_geo + h_geo;
        yr1_reg <= y_geo + r_geo - GEO_W'(1);
        yhr_reg <= y_geo + h_geo - r_geo;
        rsq_reg <= rsq_next;
    end

    // ------------------------------------------------------------------
    // pipeline flow control
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;

    assign en4 = !v4_reg || m_tready;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign s_tready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= s_tvalid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: capture
    // ------------------------------------------------------------------
    logic [COORD_W-1:0] s1_px_reg, s1_py_reg;
    logic [PIX_W-1:0]   s1_bg_reg;

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_px_reg <= s_tdata[COORD_W-1:0];
            s1_py_reg <= s_tdata[2*COORD_W-1:COORD_W];
            s1_bg_reg <= s_tdata[2*COORD_W+PIX_W-1:2*COORD_W];
        end
    end

    // ------------------------------------------------------------------
    // stage 2: box test and corner pick
    // ------------------------------------------------------------------
    logic signed [GEO_W-1:0] px_geo, py_geo;
    logic signed [GEO_W-1:0] dxl, dxr, dyt, dyb;
    logic signed [GEO_W-1:0] dx_next, dy_next;
    logic is_left, is_right, is_top, is_bottom;
    logic inside_next, corner_next;

    assign px_geo = signed'(GEO_W'(s1_px_reg));
    assign py_geo = signed'(GEO_W'(s1_py_reg));

    assign dxl = xr1_reg - px_geo;
    assign dxr = px_geo - xwr_reg;
    assign dyt = yr1_reg - py_geo;
    assign dyb = py_geo - yhr_reg;

    assign is_left   = px_geo <= xr1_reg;
    assign is_right  = px_geo >= xwr_reg;
    assign is_top    = py_geo <= yr1_reg;
    assign is_bottom = py_geo >= yhr_reg;

    assign inside_next = (px_geo >= xl_reg) && (px_geo < xw_reg)
                      && (py_geo >= yt_reg) && (py_geo < yh_reg)
                      && ({1'b0, s1_px_reg} < SCR_WIDTH)
                      && ({1'b0, s1_py_reg} < SCR_HEIGHT);

    // corners in priority order: top-left, top-right, bottom-left, bottom-right
    always_comb
    begin
        corner_next = 1'b1;
        dx_next     = dxl;
        dy_next     = dyt;
        if (is_left && is_top)
        begin
            dx_next = dxl;
            dy_next = dyt;
        end
        else if (is_right && is_top)
        begin
            dx_next = dxr;
            dy_next = dyt;
        end
        else if (is_left && is_bottom)
        begin
            dx_next = dxl;
            dy_next = dyb;
        end
        else if (is_right && is_bottom)
        begin
            dx_next = dxr;
            dy_next = dyb;
        end
        else
        begin
            corner_next = 1'b0;
        end
    end

    logic                    s2_inside_reg, s2_corner_reg;
    logic signed [GEO_W-1:0] s2_dx_reg, s2_dy_reg;
    logic [PIX_W-1:0]        s2_bg_reg;

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            s2_inside_reg <= inside_next;
            s2_corner_reg <= corner_next;
            s2_dx_reg     <= dx_next;
            s2_dy_reg     <= dy_next;
            s2_bg_reg     <= s1_bg_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: distance squares and channel products
    // ------------------------------------------------------------------
    logic signed [2*GEO_W-1:0] dx_sq_full, dy_sq_full;
    logic [CH_W-1:0]           alpha, alpha_inv;
    logic [PROD_W-1:0]         fa_next [NUM_CH];
    logic [PROD_W-1:0]         ba_next [NUM_CH];

    assign dx_sq_full = s2_dx_reg * s2_dx_reg;
    assign dy_sq_full = s2_dy_reg * s2_dy_reg;
    assign alpha      = fill_reg[ALPHA_LSB +: CH_W];
    assign alpha_inv  = CH_MAX - alpha;

    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            fa_next[c] = fill_reg[c*CH_W +: CH_W] * alpha;
            ba_next[c] = s2_bg_reg[c*CH_W +: CH_W] * alpha_inv;
        end
    end

    logic              s3_inside_reg, s3_corner_reg;
    logic [SQ_W-1:0]   s3_dx_sq_reg, s3_dy_sq_reg;
    logic [PROD_W-1:0] s3_fa_reg [NUM_CH];
    logic [PROD_W-1:0] s3_ba_reg [NUM_CH];
    logic [PIX_W-1:0]  s3_bg_reg;

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            s3_inside_reg <= s2_inside_reg;
            s3_corner_reg <= s2_corner_reg;
            s3_dx_sq_reg  <= dx_sq_full[SQ_W-1:0];
            s3_dy_sq_reg  <= dy_sq_full[SQ_W-1:0];
            s3_bg_reg     <= s2_bg_reg;
            for (int c = 0; c < NUM_CH; c++)
            begin
                s3_fa_reg[c] <= fa_next[c];
                s3_ba_reg[c] <= ba_next[c];
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 4: radius compare, divide by 255, output word
    // ------------------------------------------------------------------
    logic [SQ_W:0]       dist_sq;
    logic                covered_next;
    logic [PROD_W-1:0]   mix_sum  [NUM_CH];
    logic [PROD_W:0]     mix_corr [NUM_CH];
    logic [PIX_W-1:0]    blend_pix;

    assign dist_sq = {1'b0, s3_dx_sq_reg} + {1'b0, s3_dy_sq_reg};
    assign covered_next = s3_inside_reg
                       && (!s3_corner_reg || (dist_sq <= (SQ_W+1)'(rsq_reg)));

    // exact floor(s / 255) for s up to 255 * 255: (s + (s >> 8) + 1) >> 8
    always_comb
    begin
        blend_pix = {CH_MAX, {(PIX_W-CH_W){1'b0}}};
        for (int c = 0; c < NUM_CH; c++)
        begin
            mix_sum[c]  = s3_fa_reg[c] + s3_ba_reg[c];
            mix_corr[c] = {1'b0, mix_sum[c]} + (PROD_W+1)'(mix_sum[c][PROD_W-1:CH_W])
                        + (PROD_W+1)'(1);
            blend_pix[c*CH_W +: CH_W] = mix_corr[c][PROD_W-1:CH_W];
        end
    end

    logic [PIX_W-1:0] s4_pix_reg;
    logic             s4_covered_reg;

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            s4_pix_reg     <= covered_next ? blend_pix : s3_bg_reg;
            s4_covered_reg <= covered_next;
        end
    end

    assign m_tvalid = v4_reg;
    assign m_tdata  = s4_pix_reg;
    assign m_tuser  = s4_covered_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `RRAF_ASSERT_IMPL(a_covered_opaque, clk, rst_n, m_tvalid && m_tuser,
        m_tdata[ALPHA_LSB +: CH_W] == CH_MAX)
    `RRAF_ASSERT_IMPL(a_stall_only_full, clk, rst_n, !s_tready,
        v1_reg && v2_reg && v3_reg && v4_reg && !m_tready)
    `RRAF_ASSERT_NEXT(a_accept_lands, clk, rst_n, s_tvalid && s_tready, v1_reg)

endmodule

`default_nettype wire
